[rtl/core/mwsg_pkg.sv]
// Package with shared types, constants and waveform lookup tables for the sample generator.
package mwsg_pkg;

    // Table sizes
    localparam int SINE_TABLE_BITS = 8;
    localparam int EXP_TABLE_BITS  = 6;
    localparam int SINE_SIZE       = 1 << SINE_TABLE_BITS;
    localparam int EXP_SIZE        = (1 << EXP_TABLE_BITS) + 1;
    localparam int EXP_IDX_W       = EXP_TABLE_BITS + 1;

    // Noise generator
    localparam logic [31:0] LFSR_SEED = 32'hACE1_ACE1;
    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    // Fixed-point helpers used when building the tables
    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam longint Q30_TWO_PI = 64'sd6746518852;

    // Phase constants (Q0.16 turns)
    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam logic [15:0] HALF_TURN    = 16'h8000;
    localparam logic [15:0] THREE_QUARTER_TURN = 16'hC000;

    // Queue between front and back
    localparam int Q_PTR_W = 2;
    localparam int Q_DEPTH = 1 << Q_PTR_W;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [3:0] {
        WAVE_SINE     = 4'd0,
        WAVE_COSINE   = 4'd1,
        WAVE_SQUARE   = 4'd2,
        WAVE_TRIANGLE = 4'd3,
        WAVE_SAWTOOTH = 4'd4,
        WAVE_PULSE    = 4'd5,
        WAVE_NOISE    = 4'd6,
        WAVE_DECAY    = 4'd7,
        WAVE_ABS_SINE = 4'd8
    } t_wave;

    typedef enum logic [2:0] {
        REG_WAVE_TYPE       = 3'd0,
        REG_INVERT_OUTPUT   = 3'd1,
        REG_AMPLITUDE       = 3'd2,
        REG_CYCLES_PER_UNIT = 3'd3,
        REG_DUTY_CYCLE      = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [3:0]  wave_type;
        logic        invert_output;
        logic [15:0] amplitude;
        logic [15:0] cycles_per_unit;
        logic [15:0] duty_cycle;
    } t_cfg;

    // One request after the front end has worked out its phase
    typedef struct packed {
        logic [15:0]          phase;
        logic [EXP_IDX_W-1:0] exp_idx;
        logic [3:0]           wave;
        logic [15:0]          noise;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef logic [SINE_SIZE-1:0][15:0] t_sine_rom;
    typedef logic [EXP_SIZE-1:0][16:0]  t_exp_rom;

    function automatic longint q30_to_q15(longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r < 0) r = 0;
        if (r > 32767) r = 32767;
        return r;
    endfunction

    // Full-turn sine table in Q1.15, from a Taylor series on the first quadrant.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        longint    f;
        longint    quad;
        longint    r;
        longint    a;
        longint    a2;
        longint    term;
        longint    sum;
        longint    m;
        for (int i = 0; i < SINE_SIZE; i++) begin
            f    = (longint'(i) << (16 - SINE_TABLE_BITS)) & 64'sh FFFF;
            quad = f >>> 14;
            r    = f & 64'sh3FFF;
            if (quad[0]) r = 64'sd16384 - r;
            a    = (r * Q30_TWO_PI) >>> 16;
            a2   = (a * a) >>> 30;
            term = a;
            sum  = a;
            term = ((term * a2) >>> 30) / 6;   sum = sum - term;
            term = ((term * a2) >>> 30) / 20;  sum = sum + term;
            term = ((term * a2) >>> 30) / 42;  sum = sum - term;
            term = ((term * a2) >>> 30) / 72;  sum = sum + term;
            term = ((term * a2) >>> 30) / 110; sum = sum - term;
            term = ((term * a2) >>> 30) / 156; sum = sum + term;
            term = ((term * a2) >>> 30) / 210; sum = sum - term;
            if (sum < 0) sum = 0;
            m = q30_to_q15(sum);
            rom[i] = quad[1] ? 16'(-m) : 16'(m);
        end
        return rom;
    endfunction

    // exp(-u) for u in [0, 1] in Q1.15; the first entry is exactly one.
    function automatic t_exp_rom build_exp_rom();
        t_exp_rom rom;
        longint   u;
        longint   term;
        longint   sum;
        longint   m;
        for (int i = 0; i < EXP_SIZE; i++) begin
            u    = longint'(i) << (30 - EXP_TABLE_BITS);
            term = Q30_ONE;
            sum  = Q30_ONE;
            term = ((term * u) >>> 30) / 1;  sum = sum - term;
            term = ((term * u) >>> 30) / 2;  sum = sum + term;
            term = ((term * u) >>> 30) / 3;  sum = sum - term;
            term = ((term * u) >>> 30) / 4;  sum = sum + term;
            term = ((term * u) >>> 30) / 5;  sum = sum - term;
            term = ((term * u) >>> 30) / 6;  sum = sum + term;
            term = ((term * u) >>> 30) / 7;  sum = sum - term;
            term = ((term * u) >>> 30) / 8;  sum = sum + term;
            term = ((term * u) >>> 30) / 9;  sum = sum - term;
            term = ((term * u) >>> 30) / 10; sum = sum + term;
            term = ((term * u) >>> 30) / 11; sum = sum - term;
            term = ((term * u) >>> 30) / 12; sum = sum + term;
            term = ((term * u) >>> 30) / 13; sum = sum - term;
            m = q30_to_q15(sum);
            if (i == 0 && m == 32767) begin
                rom[i] = 17'd32768;
            end else begin
                rom[i] = 17'(m);
            end
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();
    localparam t_exp_rom  EXP_ROM  = build_exp_rom();

endpackage

[rtl/core/mwsg_ifs.sv]
// Valid/ready channel interfaces for the sample generator's request and result streams.
interface mwsg_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_position;
    logic        [15:0] time_phase;

    modport source (output valid, output x_position, output time_phase, input ready);
    modport sink   (input valid, input x_position, input time_phase, output ready);
endinterface

interface mwsg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[rtl/core/mwsg_regs.sv]
// APB configuration register file for the sample generator.
module mwsg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mwsg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mwsg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mwsg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output mwsg_pkg::t_cfg                   o_cfg
);

    mwsg_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_type       <= mwsg_pkg::WAVE_SINE;
            r_cfg.invert_output   <= 1'b0;
            r_cfg.amplitude       <= 16'd32768;
            r_cfg.cycles_per_unit <= 16'd4096;
            r_cfg.duty_cycle      <= 16'd32768;
        end else if (wr_en) begin
            case (mwsg_pkg::t_reg_idx'(reg_idx))
                mwsg_pkg::REG_WAVE_TYPE:       r_cfg.wave_type       <= pwdata[3:0];
                mwsg_pkg::REG_INVERT_OUTPUT:   r_cfg.invert_output   <= pwdata[0];
                mwsg_pkg::REG_AMPLITUDE:       r_cfg.amplitude       <= pwdata[15:0];
                mwsg_pkg::REG_CYCLES_PER_UNIT: r_cfg.cycles_per_unit <= pwdata[15:0];
                mwsg_pkg::REG_DUTY_CYCLE:      r_cfg.duty_cycle      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (mwsg_pkg::t_reg_idx'(reg_idx))
            mwsg_pkg::REG_WAVE_TYPE:       prdata = {28'd0, r_cfg.wave_type};
            mwsg_pkg::REG_INVERT_OUTPUT:   prdata = {31'd0, r_cfg.invert_output};
            mwsg_pkg::REG_AMPLITUDE:       prdata = {16'd0, r_cfg.amplitude};
            mwsg_pkg::REG_CYCLES_PER_UNIT: prdata = {16'd0, r_cfg.cycles_per_unit};
            mwsg_pkg::REG_DUTY_CYCLE:      prdata = {16'd0, r_cfg.duty_cycle};
            default:                       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/mwsg_front.sv]
// Front end: accepts requests, computes the phase and exp index, and steps the noise LFSR.
module mwsg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mwsg_pkg::t_cfg      i_cfg,
    mwsg_in_if.sink             i_req,
    input  mwsg_pkg::t_q_status i_q_status,
    output logic                o_push,
    output mwsg_pkg::t_item     o_item
);

    logic [31:0]        r_lfsr;
    logic [31:0]        n_lfsr;
    logic signed [32:0] prod;
    logic [15:0]        abs_x;
    logic               is_noise;

    assign i_req.ready = !i_q_status.full;
    assign o_push      = i_req.valid && !i_q_status.full;
    assign is_noise    = (i_cfg.wave_type == mwsg_pkg::WAVE_NOISE);

    // cycles_per_unit (Q4.12) times x (Q1.15) is Q5.27; bits 26..11 are the Q0.16 turn.
    assign prod  = $signed({1'b0, i_cfg.cycles_per_unit}) * i_req.x_position;
    assign abs_x = i_req.x_position[15] ? 16'(-i_req.x_position) : i_req.x_position;

    // Galois step: shift right and fold in the taps when the dropped bit was one.
    assign n_lfsr = (r_lfsr >> 1) ^ (r_lfsr[0] ? mwsg_pkg::LFSR_TAPS : 32'd0);

    always_comb begin
        o_item.phase   = prod[26:11] + i_req.time_phase;
        o_item.exp_idx = abs_x[15 -: mwsg_pkg::EXP_IDX_W];
        o_item.wave    = i_cfg.wave_type;
        o_item.noise   = n_lfsr[31:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= mwsg_pkg::LFSR_SEED;
        end else if (o_push && is_noise) begin
            r_lfsr <= n_lfsr;
        end
    end

endmodule

[rtl/core/mwsg_queue.sv]
// Small FIFO that decouples the front end from the back end.
module mwsg_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mwsg_pkg::t_item     i_item,
    input  logic                i_pop,
    output mwsg_pkg::t_item     o_item,
    output mwsg_pkg::t_q_status o_status
);

    mwsg_pkg::t_item              r_mem [mwsg_pkg::Q_DEPTH];
    logic [mwsg_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [mwsg_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [mwsg_pkg::Q_PTR_W:0]   r_count;

    assign o_status.full  = (r_count == (mwsg_pkg::Q_PTR_W + 1)'(mwsg_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/mwsg_back.sv]
// Back end: table lookup, waveform shaping, decay product, gain scaling and saturation.
module mwsg_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mwsg_pkg::t_cfg      i_cfg,
    input  mwsg_pkg::t_item     i_item,
    input  mwsg_pkg::t_q_status i_q_status,
    output logic                o_pop,
    mwsg_out_if.source          o_rsp
);

    // Stage valid bits; the last one is the output register.
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic adv;

    // Stage 1 results
    logic signed [16:0] r_w1;
    logic signed [15:0] r_sv;
    logic        [16:0] r_e;
    logic               r_decay;

    // Stage 2 result
    logic signed [16:0] r_w2;

    // Stage 3 result
    logic signed [15:0] r_sample;

    // Stage 1 signals
    logic [15:0]                         sine_phase;
    logic [mwsg_pkg::SINE_TABLE_BITS-1:0] sine_idx;
    logic signed [15:0]                  sv;
    logic signed [18:0]                  twice_p;
    logic signed [18:0]                  tri_w;
    logic signed [16:0]                  n_w1;

    // Stage 2 signals
    logic signed [33:0] dec_prod;
    logic signed [33:0] dec_sum;
    logic signed [16:0] w_pre;
    logic signed [16:0] n_w2;

    // Stage 3 signals
    logic signed [33:0] amp_prod;
    logic signed [33:0] amp_sum;
    logic signed [33:0] y;
    logic signed [15:0] n_sample;

    // The whole back pipeline moves together unless the result register is held.
    assign adv   = !r_v3 || o_rsp.ready;
    assign o_pop = adv && !i_q_status.empty;

    always_comb begin
        sine_phase = (i_item.wave == mwsg_pkg::WAVE_COSINE) ?
                     i_item.phase + mwsg_pkg::QUARTER_TURN : i_item.phase;
        sine_idx   = sine_phase[15 -: mwsg_pkg::SINE_TABLE_BITS];
        sv         = $signed(mwsg_pkg::SINE_ROM[sine_idx]);
        twice_p    = $signed({2'b0, i_item.phase, 1'b0});

        if (i_item.phase < mwsg_pkg::QUARTER_TURN) begin
            tri_w = twice_p;
        end else if (i_item.phase < mwsg_pkg::THREE_QUARTER_TURN) begin
            tri_w = 19'sd65536 - twice_p;
        end else begin
            tri_w = twice_p - 19'sd131072;
        end

        case (mwsg_pkg::t_wave'(i_item.wave))
            mwsg_pkg::WAVE_SINE,
            mwsg_pkg::WAVE_COSINE:   n_w1 = 17'(sv);
            mwsg_pkg::WAVE_SQUARE:   n_w1 = (i_item.phase != 16'd0 && !i_item.phase[15]) ?
                                            17'sd32768 : -17'sd32768;
            mwsg_pkg::WAVE_TRIANGLE: n_w1 = tri_w[16:0];
            mwsg_pkg::WAVE_SAWTOOTH: n_w1 = 17'($signed(i_item.phase));
            mwsg_pkg::WAVE_PULSE:    n_w1 = (i_item.phase < i_cfg.duty_cycle) ?
                                            17'sd32768 : -17'sd32768;
            mwsg_pkg::WAVE_NOISE:    n_w1 = 17'($signed(i_item.noise));
            mwsg_pkg::WAVE_ABS_SINE: n_w1 = sv[15] ? -17'(sv) : 17'(sv);
            default:                 n_w1 = '0;
        endcase
    end

    // Decaying sine: sine times exp(-|x|), rounded half up back to Q1.15.
    always_comb begin
        dec_prod = r_sv * $signed({1'b0, r_e});
        dec_sum  = dec_prod + 34'sd16384;
        w_pre    = r_decay ? dec_sum[31:15] : r_w1;
        n_w2     = i_cfg.invert_output ? -w_pre : w_pre;
    end

    // Gain in unsigned Q1.15, rounded half up and clamped to the signed Q1.15 range.
    always_comb begin
        amp_prod = r_w2 * $signed({1'b0, i_cfg.amplitude});
        amp_sum  = amp_prod + 34'sd16384;
        y        = amp_sum >>> 15;
        if (y > 34'sd32767) begin
            n_sample = 16'sh7FFF;
        end else if (y < -34'sd32768) begin
            n_sample = 16'sh8000;
        end else begin
            n_sample = y[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= !i_q_status.empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w1     <= n_w1;
            r_sv     <= sv;
            r_e      <= mwsg_pkg::EXP_ROM[i_item.exp_idx];
            r_decay  <= (i_item.wave == mwsg_pkg::WAVE_DECAY);
            r_w2     <= n_w2;
            r_sample <= n_sample;
        end
    end

    assign o_rsp.valid  = r_v3;
    assign o_rsp.sample = r_sample;

endmodule

[rtl/core/multi_waveform_sample_generator.sv]
// Top level of the multi-waveform sample generator.
//
//   Port         Direction  Handshake        Payload
//   i_req        in         valid / ready    x_position (s16 Q1.15), time_phase (u16 turns)
//   o_rsp        out        valid / ready    sample (s16 Q1.15)
//   APB (p*)     in/out     psel + penable   wave_type, invert_output, amplitude,
//                                            cycles_per_unit, duty_cycle
//
// One request is accepted per clock while the four-entry queue has room, and one result
// leaves per clock while the sink takes it. An accepted request is written into the queue
// at the accepting edge, then passes through three registered back-end stages (table
// lookup, decay product, gain multiply with saturation) before its result is valid.
// Reset is synchronous and active low; it loads the register defaults, reseeds the noise
// LFSR and empties the queue and the back-end pipeline. There is no clearing pass.
// A stalled result holds the back end; the front keeps accepting until the queue fills.
module multi_waveform_sample_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mwsg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mwsg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mwsg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    mwsg_in_if.sink                          i_req,
    mwsg_out_if.source                       o_rsp
);

    mwsg_pkg::t_cfg      cfg;
    mwsg_pkg::t_item     push_item;
    mwsg_pkg::t_item     head_item;
    mwsg_pkg::t_q_status q_status;
    logic                push;
    logic                pop;

    // Software must write these registers only while no request is in flight; unenforced.
    mwsg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The front end turns position and time into a phase in turns, picks the exp table
    // index from |x| and advances the noise LFSR once for every noise request it accepts.
    mwsg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_req      (i_req),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (push_item)
    );

    // The queue lets the front keep taking requests while a result waits at the output.
    mwsg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    // The back end shapes the waveform, applies inversion and gain, and holds the result
    // in its output register until the sink takes it.
    mwsg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_item     (head_item),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_rsp      (o_rsp)
    );

endmodule

[tb/multi_waveform_sample_generator_test.sv]
// Self-checking testbench for the multi-waveform sample generator.
`timescale 1ns / 100ps

module multi_waveform_sample_generator_test;

    // The limit on quiet cycles covers the longest receiver stall, the longest sender gap,
    // a full register update and the pipeline depth, with a wide margin.
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int TAIL_CYCLES    = 12;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_PHASES  = 12;
    localparam int REQS_PER_PHASE = 75;

    // Table geometry and fixed-point constants of the predictor.
    localparam int     SINE_BITS    = 8;
    localparam int     EXP_BITS     = 6;
    localparam int     SINE_ENTRIES = 1 << SINE_BITS;
    localparam int     EXP_ENTRIES  = (1 << EXP_BITS) + 1;
    localparam longint ONE_Q30      = 64'sd1073741824;
    localparam longint TWO_PI_Q30   = 64'sd6746518852;

    localparam logic [31:0] NOISE_SEED = 32'hACE1_ACE1;
    localparam logic [31:0] NOISE_TAPS = 32'h8020_0003;

    // Phase points in turns, Q0.16.
    localparam logic [15:0] QUARTER_T = 16'h4000;
    localparam logic [15:0] HALF_T    = 16'h8000;
    localparam logic [15:0] THREEQ_T  = 16'hC000;

    // Register values used by name.
    localparam logic [15:0] GAIN_UNITY    = 16'h8000;
    localparam logic [15:0] GAIN_MAX      = 16'hFFFF;
    localparam logic [15:0] CYCLES_UNITY  = 16'h1000;
    localparam logic [3:0]  WAVE_UNKNOWN  = 4'd9;
    localparam logic [3:0]  WAVE_CODE_MAX = 4'd15;

    // The predictor and checker. It keeps its own copy of the registers and of the noise
    // register, builds the sine and exp tables the same way the block is specified to,
    // and holds the samples that are still owed by the block, oldest first.
    class sample_scoreboard;
        logic [3:0]  wave;
        logic        invert;
        logic [15:0] gain;
        logic [15:0] cycles;
        logic [15:0] duty;
        logic [31:0] noise_state;
        longint      sine_tab[SINE_ENTRIES];
        longint      exp_tab[EXP_ENTRIES];
        logic [15:0] expected_samples[$];
        int          error_count;

        function new();
            longint f;
            longint quad;
            longint r;
            longint a;
            longint a2;
            longint term;
            longint sum;
            longint m;
            longint u;
            wave        = mwsg_pkg::WAVE_SINE;
            invert      = 1'b0;
            gain        = GAIN_UNITY;
            cycles      = CYCLES_UNITY;
            duty        = HALF_T;
            noise_state = NOISE_SEED;
            error_count = 0;
            // Sine over a full turn: Taylor series on the first quadrant, mirrored.
            for (int i = 0; i < SINE_ENTRIES; i++) begin
                f    = (longint'(i) << (16 - SINE_BITS)) & 64'hFFFF;
                quad = f >>> 14;
                r    = f & 64'h3FFF;
                if (quad[0]) r = 64'sd16384 - r;
                a    = (r * TWO_PI_Q30) >>> 16;
                a2   = (a * a) >>> 30;
                term = a;
                sum  = a;
                for (int n = 1; n <= 7; n++) begin
                    term = ((term * a2) >>> 30) / ((2 * n) * (2 * n + 1));
                    sum  = n[0] ? sum - term : sum + term;
                end
                if (sum < 0) sum = 0;
                m = to_q15(sum);
                sine_tab[i] = quad[1] ? -m : m;
            end
            // exp(-u) on [0, 1]; the entry at zero is exactly one.
            for (int i = 0; i < EXP_ENTRIES; i++) begin
                u    = longint'(i) << (30 - EXP_BITS);
                term = ONE_Q30;
                sum  = ONE_Q30;
                for (int k = 1; k <= 13; k++) begin
                    term = ((term * u) >>> 30) / k;
                    sum  = k[0] ? sum - term : sum + term;
                end
                m = to_q15(sum);
                exp_tab[i] = (i == 0 && m == 32767) ? 64'sd32768 : m;
            end
        endfunction

        function longint to_q15(longint v);
            longint q;
            q = (v + 64'sd16384) >>> 15;
            if (q < 0) q = 0;
            if (q > 32767) q = 32767;
            return q;
        endfunction

        function void write_reg(mwsg_pkg::t_reg_idx idx, logic [31:0] value);
            case (idx)
                mwsg_pkg::REG_WAVE_TYPE:       wave   = value[3:0];
                mwsg_pkg::REG_INVERT_OUTPUT:   invert = value[0];
                mwsg_pkg::REG_AMPLITUDE:       gain   = value[15:0];
                mwsg_pkg::REG_CYCLES_PER_UNIT: cycles = value[15:0];
                mwsg_pkg::REG_DUTY_CYCLE:      duty   = value[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        // Works out the sample for one accepted request and queues it.
        function void take_request(logic signed [15:0] x, logic [15:0] tp);
            logic [63:0] prod_bits;
            logic [15:0] p;
            logic [15:0] pc;
            logic        lsb;
            longint      pl;
            longint      w;
            longint      y;
            int          ax;
            prod_bits = longint'(cycles) * longint'(x);
            p  = prod_bits[26:11] + tp;
            pc = p + QUARTER_T;
            pl = longint'(p);
            case (wave)
                mwsg_pkg::WAVE_SINE:     w = sine_tab[p >> (16 - SINE_BITS)];
                mwsg_pkg::WAVE_COSINE:   w = sine_tab[pc >> (16 - SINE_BITS)];
                mwsg_pkg::WAVE_SQUARE:
                    w = (p > 0 && p < HALF_T) ? 64'sd32768 : -64'sd32768;
                mwsg_pkg::WAVE_TRIANGLE: begin
                    if (p < QUARTER_T) w = 2 * pl;
                    else if (p < THREEQ_T) w = 64'sd65536 - 2 * pl;
                    else w = 2 * pl - 64'sd131072;
                end
                mwsg_pkg::WAVE_SAWTOOTH: w = (p < HALF_T) ? pl : pl - 64'sd65536;
                mwsg_pkg::WAVE_PULSE:    w = (p < duty) ? 64'sd32768 : -64'sd32768;
                mwsg_pkg::WAVE_NOISE: begin
                    lsb = noise_state[0];
                    noise_state = noise_state >> 1;
                    if (lsb) noise_state = noise_state ^ NOISE_TAPS;
                    w = longint'($signed(noise_state[31:16]));
                end
                mwsg_pkg::WAVE_DECAY: begin
                    ax = (x < 0) ? -int'(x) : int'(x);
                    w = (sine_tab[p >> (16 - SINE_BITS)] * exp_tab[ax >> (15 - EXP_BITS)]
                         + 64'sd16384) >>> 15;
                end
                mwsg_pkg::WAVE_ABS_SINE: begin
                    w = sine_tab[p >> (16 - SINE_BITS)];
                    if (w < 0) w = -w;
                end
                default: w = 0;
            endcase
            if (invert) w = -w;
            y = (w * longint'(gain) + 64'sd16384) >>> 15;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            expected_samples.push_back(16'(y));
        endfunction

        task report_error(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            error_count++;
        endtask

        task check_sample(logic [15:0] got);
            logic [15:0] want;
            if (expected_samples.size() == 0) begin
                report_error($sformatf("sample %0d arrived with no request waiting",
                                       $signed(got)));
                return;
            end
            want = expected_samples.pop_front();
            if (got !== want)
                report_error($sformatf("sample %0d, expected %0d", $signed(got), $signed(want)));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    // Configuration port.
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [mwsg_pkg::APB_ADDR_W-1:0] paddr;
    logic [mwsg_pkg::APB_DATA_W-1:0] pwdata;
    logic [mwsg_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    mwsg_in_if  req_ch();
    mwsg_out_if rsp_ch();

    // Idling switches, changed per phase of the random part.
    bit req_idle_en;
    bit rsp_idle_en;

    sample_scoreboard model;

    multi_waveform_sample_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Gap lengths: mostly none, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // A value that lands on one of three corner values three times in eight.
    function automatic logic [15:0] pick_value(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        case ($urandom_range(0, 7))
            0:       return a;
            1:       return b;
            2:       return c;
            default: return 16'($urandom);
        endcase
    endfunction

    // One register write: setup cycle, then access cycle until pready. psel stays high so
    // that back-to-back writes never lower and raise it within one time step; the caller
    // releases the bus.
    task automatic apb_write(mwsg_pkg::t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        model.write_reg(idx, value);
    endtask

    // Loads all five registers. Only called while the block holds no request.
    task automatic configure_generator(logic [3:0] wave, logic inv, logic [15:0] gain,
                                       logic [15:0] cycles, logic [15:0] duty);
        apb_write(mwsg_pkg::REG_WAVE_TYPE,       {28'd0, wave});
        apb_write(mwsg_pkg::REG_INVERT_OUTPUT,   {31'd0, inv});
        apb_write(mwsg_pkg::REG_AMPLITUDE,       {16'd0, gain});
        apb_write(mwsg_pkg::REG_CYCLES_PER_UNIT, {16'd0, cycles});
        apb_write(mwsg_pkg::REG_DUTY_CYCLE,      {16'd0, duty});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Presents one request, after an optional gap, and holds it until it is taken. The
    // prediction is made at the edge that accepts it, so the expectation is always queued
    // well before the matching sample can come back.
    task automatic send_request(logic signed [15:0] x, logic [15:0] tp);
        int gap;
        gap = req_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.x_position <= x;
        req_ch.time_phase <= tp;
        do @(posedge i_clk); while (!req_ch.ready);
        model.take_request(x, tp);
    endtask

    // Withdraws the request and waits until every owed sample has come back.
    task automatic wait_for_samples();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (model.pending() != 0) @(posedge i_clk);
    endtask

    // Result side: checks each accepted sample and stalls ready in random bursts.
    initial begin : result_sink
        int hold;
        int gap;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) model.check_sample(rsp_ch.sample);
            if (hold > 0) begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end else begin
                gap = rsp_idle_en ? pick_gap() : 0;
                if (gap > 0) begin
                    hold = gap - 1;
                    rsp_ch.ready <= 1'b0;
                end else begin
                    rsp_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Ends the run if neither stream moves for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        logic [3:0]  other_waves[6];
        logic [3:0]  wave;
        logic [15:0] gain;
        logic [15:0] cycles;
        logic [15:0] duty;
        int          r;
        other_waves = '{mwsg_pkg::WAVE_COSINE, mwsg_pkg::WAVE_TRIANGLE,
                        mwsg_pkg::WAVE_SAWTOOTH, mwsg_pkg::WAVE_NOISE,
                        mwsg_pkg::WAVE_ABS_SINE, WAVE_UNKNOWN};
        model = new();

        // Every input is known from time zero; reset is held low at the start, then released.
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.x_position <= '0;
        req_ch.time_phase <= '0;
        req_idle_en       = 1'b0;
        rsp_idle_en       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The reset settings give a sine at one cycle per unit; the ends of
        // the position range and of the time phase come first.
        send_request(-16'sd32768, 16'h0000);
        send_request(16'sd32767, 16'hFFFF);
        send_request(16'sd0, QUARTER_T);

        // Square at unity gain: zero phase is low, the quarter point is a full-scale
        // high that must saturate to the largest positive sample.
        wait_for_samples();
        configure_generator(mwsg_pkg::WAVE_SQUARE, 1'b0, GAIN_UNITY, CYCLES_UNITY, HALF_T);
        send_request(16'sd0, 16'h0000);
        send_request(16'sd0, QUARTER_T);
        send_request(16'sd0, HALF_T);

        // Pulse with zero duty stays low everywhere, here with the gain above one.
        wait_for_samples();
        configure_generator(mwsg_pkg::WAVE_PULSE, 1'b0, GAIN_MAX, CYCLES_UNITY, 16'h0000);
        send_request(16'sd0, 16'h0000);
        send_request(16'sd0, 16'hFFFF);

        // Decaying sine: the most negative position reaches the last entry of the exp table.
        wait_for_samples();
        configure_generator(mwsg_pkg::WAVE_DECAY, 1'b0, GAIN_UNITY, 16'h0000, HALF_T);
        send_request(-16'sd32768, QUARTER_T);
        send_request(16'sd32767, THREEQ_T);

        // The remaining shapes and an unknown code, inverted.
        foreach (other_waves[i]) begin
            wait_for_samples();
            configure_generator(other_waves[i], 1'b1, GAIN_UNITY, CYCLES_UNITY, HALF_T);
            send_request(16'sh2000, 16'h1234);
        end

        // Random part. Each phase loads a new setting; the first two pin every register
        // but the wave type at its top and bottom. The phase number selects which side
        // idles, so phase zero of every group of four runs without gaps.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_for_samples();
            r = $urandom_range(0, 19);
            wave = (r < 18) ? 4'(r % 9) : 4'($urandom_range(WAVE_UNKNOWN, WAVE_CODE_MAX));
            if (phase == 0) begin
                configure_generator(wave, 1'b1, GAIN_MAX, 16'hFFFF, 16'hFFFF);
            end else if (phase == 1) begin
                configure_generator(wave, 1'b0, 16'h0000, 16'h0000, 16'h0000);
            end else begin
                gain   = pick_value(16'h0000, GAIN_UNITY, GAIN_MAX);
                cycles = pick_value(16'h0000, CYCLES_UNITY, 16'hFFFF);
                duty   = pick_value(16'h0000, HALF_T, 16'hFFFF);
                configure_generator(wave, 1'($urandom), gain, cycles, duty);
            end
            req_idle_en = phase[0];
            rsp_idle_en <= phase[1];

            for (int n = 0; n < REQS_PER_PHASE; n++) begin
                // Halfway through, the sender sometimes waits for the pipeline to empty.
                if (n == REQS_PER_PHASE / 2 && (phase == 2 || $urandom_range(0, 3) == 0))
                    wait_for_samples();
                send_request(pick_value(16'h8000, 16'h7FFF, 16'h0000),
                             pick_value(16'h0000, 16'hFFFF, QUARTER_T));
            end
        end

        // Drain, then leave time for any sample the block should not have produced.
        wait_for_samples();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (model.error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
